FILE: hdl/bsd_pkg.sv
// Shared widths, defaults, register indexes and the accumulator entry type.
package bsd_pkg;

  localparam int MAX_FRAME_WIDTH_DEF      = 256;
  localparam int MAX_FRAME_HEIGHT_DEF     = 256;
  localparam int WEIGHT_FRACTION_BITS_DEF = 8;

  localparam int PIXEL_W = 32;
  localparam int COORD_W = 20;
  localparam int FSIZE_W = 9;
  localparam int SUM_W   = 44;
  localparam int AREA_W  = 36;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOCATION_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCATION_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SUM_W-1:0]  red;
    logic [SUM_W-1:0]  green;
    logic [SUM_W-1:0]  blue;
    logic [AREA_W-1:0] area;
  } acc_entry_t;

endpackage

FILE: hdl/bsd_if.sv
// Handshake interfaces for the pixel transaction and the frame pixel transaction.
interface bsd_in_if import bsd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [PIXEL_W-1:0] source_pixel;
  logic [COORD_W-1:0] source_col;
  logic [COORD_W-1:0] source_row;

  modport source (output valid, action, source_pixel, source_col, source_row, input ready);
  modport sink (input valid, action, source_pixel, source_col, source_row, output ready);
endinterface

interface bsd_out_if import bsd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] frame_pixel_abgr;
  logic [PIXEL_W-1:0] frame_pixel_argb;
  logic               last_pixel;

  modport source (output valid, frame_pixel_abgr, frame_pixel_argb, last_pixel, input ready);
  modport sink (input valid, frame_pixel_abgr, frame_pixel_argb, last_pixel, output ready);
endinterface

FILE: hdl/bilinear_splat_downsampler_core.sv
// Bilinear splatting downsampler: sequencer, shared radix-2 divider and accumulator memory.
// Sequence: an accumulate transaction un-premultiplies (unless opaque), maps the axes through
//   the shared divider and splats up to four corners, skipping a corner off the frame; a readout
//   divides each channel sum by the area. The divider is a 44-step restoring divider.
// Throughput: one transaction at a time; in_if.ready is high only while the sequencer idles.
// Reset: registers take their reset values, then a clearing pass over all
//   MAX_FRAME_WIDTH*MAX_FRAME_HEIGHT entries zeroes the memory before the first transaction.
module bilinear_splat_downsampler_core
  import bsd_pkg::*;
#(
  parameter int MAX_FRAME_WIDTH      = MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT     = MAX_FRAME_HEIGHT_DEF,
  parameter int WEIGHT_FRACTION_BITS = WEIGHT_FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bsd_in_if.sink               in_if,
  bsd_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam int DEPTH  = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FW_W   = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int FH_W   = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int W      = WEIGHT_FRACTION_BITS;
  localparam int WW     = 2 * W + 1;
  localparam int CELL_W = 42;
  localparam int PROD_W = 2 * COORD_W;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int CHAN_W = 16;
  localparam int MUL_W  = CHAN_W + WW;

  // Sequencer state codes
  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_DIV     = 5'd2;
  localparam logic [4:0] ST_UNPM    = 5'd3;
  localparam logic [4:0] ST_UNPM_ST = 5'd4;
  localparam logic [4:0] ST_AX0     = 5'd5;
  localparam logic [4:0] ST_AX1     = 5'd6;
  localparam logic [4:0] ST_AX2     = 5'd7;
  localparam logic [4:0] ST_AX3     = 5'd8;
  localparam logic [4:0] ST_AX4     = 5'd9;
  localparam logic [4:0] ST_AX5     = 5'd10;
  localparam logic [4:0] ST_SP0     = 5'd11;
  localparam logic [4:0] ST_SP1     = 5'd12;
  localparam logic [4:0] ST_SP2     = 5'd13;
  localparam logic [4:0] ST_SP3     = 5'd14;
  localparam logic [4:0] ST_SP4     = 5'd15;
  localparam logic [4:0] ST_SP5     = 5'd16;
  localparam logic [4:0] ST_R0      = 5'd17;
  localparam logic [4:0] ST_R1      = 5'd18;
  localparam logic [4:0] ST_R2      = 5'd19;
  localparam logic [4:0] ST_R3      = 5'd20;
  localparam logic [4:0] ST_R3S     = 5'd21;
  localparam logic [4:0] ST_R4      = 5'd22;

  localparam logic [1:0] LAST_CHAN   = 2'd2;
  localparam logic [1:0] LAST_CORNER = 2'd3;
  localparam logic       AXIS_Y = 1'b0;
  localparam logic       AXIS_X = 1'b1;

  // Configuration registers
  logic [COORD_W-1:0] loc_x_r, loc_y_r, lvl_w_r, lvl_h_r, tgt_w_r, tgt_h_r;
  logic [FSIZE_W-1:0] frm_w_r, frm_h_r;

  // Sequencer and datapath registers
  logic [4:0]         state_r, ret_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [PIXEL_W-1:0] pix_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [CHAN_W-1:0]  chan_r [3];
  logic [1:0]         ch_r, k_r;
  logic               ax_r, single_r;
  logic [PROD_W-1:0]  prod_r, start_r;
  logic signed [CELL_W-1:0] cell_r, cx_r, cy_r, tx_r, ty_r;
  logic [W-1:0]       fx_r, fy_r;
  logic [WW-1:0]      w_r;
  logic [ADDR_W-1:0]  idx_r, rd_idx_r;
  logic [ADDR_W:0]    tot_r;
  acc_entry_t         acc_r, rd_data_r;
  logic [7:0]         q8_r [3];

  // Shared divider registers
  logic [SUM_W-1:0]   div_q_r;
  logic [AREA_W-1:0]  div_rem_r, div_d_r;
  logic [CNT_W-1:0]   div_cnt_r;

  // Result register
  logic               out_valid_r, out_last_r;
  logic [PIXEL_W-1:0] out_abgr_r, out_argb_r;

  acc_entry_t mem [DEPTH];

  // Combinational helpers
  logic [FW_W-1:0]   eff_fw;
  logic [FH_W-1:0]   eff_fh;
  logic [ADDR_W:0]   tot_now;
  logic [COORD_W-1:0] ax_tgt, ax_loc, ax_pos, ax_lvl, lvl_w_nz, lvl_h_nz;
  logic [AREA_W:0]   rem_try;
  logic              rem_ge;
  logic [AREA_W-1:0] rem_new;
  logic [W:0]        wx, wy, wsel_x, wsel_y;
  logic              dx, dy, in_frame, last_corner, out_free;
  logic [SUM_W-1:0]  acc_chan;
  logic [ADDR_W:0]   idx_inc;
  logic [7:0]        alpha;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  acc_entry_t        mem_wdata;

  assign alpha = pix_r[31:24];

  assign eff_fw = (frm_w_r == '0) ? FW_W'(1) :
                  (32'(frm_w_r) > 32'(MAX_FRAME_WIDTH)) ? FW_W'(MAX_FRAME_WIDTH) :
                  FW_W'(frm_w_r);
  assign eff_fh = (frm_h_r == '0) ? FH_W'(1) :
                  (32'(frm_h_r) > 32'(MAX_FRAME_HEIGHT)) ? FH_W'(MAX_FRAME_HEIGHT) :
                  FH_W'(frm_h_r);
  assign tot_now = (ADDR_W+1)'(eff_fw) * (ADDR_W+1)'(eff_fh);

  assign lvl_w_nz = (lvl_w_r == '0) ? COORD_W'(1) : lvl_w_r;
  assign lvl_h_nz = (lvl_h_r == '0) ? COORD_W'(1) : lvl_h_r;
  assign ax_tgt = (ax_r == AXIS_X) ? tgt_w_r  : tgt_h_r;
  assign ax_loc = (ax_r == AXIS_X) ? loc_x_r  : loc_y_r;
  assign ax_pos = (ax_r == AXIS_X) ? col_r    : row_r;
  assign ax_lvl = (ax_r == AXIS_X) ? lvl_w_nz : lvl_h_nz;

  // One restoring step of the divider per cycle
  assign rem_try = {div_rem_r, div_q_r[SUM_W-1]};
  assign rem_ge  = rem_try >= {1'b0, div_d_r};
  assign rem_new = rem_ge ? AREA_W'(rem_try - {1'b0, div_d_r}) : rem_try[AREA_W-1:0];

  // Bilinear corner weights: corner order is (0,0), (1,0), (1,1), (0,1)
  assign wx = (W+1)'(1 << W) - {1'b0, fx_r};
  assign wy = (W+1)'(1 << W) - {1'b0, fy_r};
  assign dx = (k_r == 2'd1) || (k_r == 2'd2);
  assign dy = (k_r == 2'd2) || (k_r == LAST_CORNER);
  assign wsel_x = dx ? {1'b0, fx_r} : wx;
  assign wsel_y = dy ? {1'b0, fy_r} : wy;
  assign last_corner = single_r || (k_r == LAST_CORNER);

  assign in_frame = !tx_r[CELL_W-1] && !ty_r[CELL_W-1] &&
                    (tx_r < $signed(CELL_W'(eff_fw))) && (ty_r < $signed(CELL_W'(eff_fh)));

  always_comb begin
    case (ch_r)
      2'd0:    acc_chan = acc_r.red;
      2'd1:    acc_chan = acc_r.green;
      default: acc_chan = acc_r.blue;
    endcase
  end

  assign idx_inc  = {1'b0, idx_r} + (ADDR_W+1)'(1);
  assign out_free = !out_valid_r || out_if.ready;

  // Single write port: clearing pass, splat write-back, readout clear
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '0;
    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      ST_SP5: begin
        mem_we    = 1'b1;
        mem_wdata = acc_r;
        mem_wdata.area = acc_r.area + AREA_W'(w_r);
      end
      ST_R4: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r];
  end

  assign in_if.ready             = (state_r == ST_IDLE);
  assign out_if.valid            = out_valid_r;
  assign out_if.frame_pixel_abgr = out_abgr_r;
  assign out_if.frame_pixel_argb = out_argb_r;
  assign out_if.last_pixel       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_x_r     <= '0;
      loc_y_r     <= '0;
      lvl_w_r     <= COORD_W'(1);
      lvl_h_r     <= COORD_W'(1);
      tgt_w_r     <= COORD_W'(1);
      tgt_h_r     <= COORD_W'(1);
      frm_w_r     <= FSIZE_W'(256);
      frm_h_r     <= FSIZE_W'(256);
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOCATION_X:    loc_x_r <= cfg_wdata;
          REG_LOCATION_Y:    loc_y_r <= cfg_wdata;
          REG_LEVEL_WIDTH:   lvl_w_r <= cfg_wdata;
          REG_LEVEL_HEIGHT:  lvl_h_r <= cfg_wdata;
          REG_TARGET_WIDTH:  tgt_w_r <= cfg_wdata;
          REG_TARGET_HEIGHT: tgt_h_r <= cfg_wdata;
          REG_FRAME_WIDTH:   frm_w_r <= cfg_wdata[FSIZE_W-1:0];
          REG_FRAME_HEIGHT:  frm_h_r <= cfg_wdata[FSIZE_W-1:0];
          default: ;
        endcase
      end

      // Raise on delivery, drop once the sink takes the transaction
      if ((state_r == ST_R4) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_if.valid) begin
            pix_r <= in_if.source_pixel;
            col_r <= in_if.source_col;
            row_r <= in_if.source_row;
            chan_r[0] <= CHAN_W'(in_if.source_pixel[23:16]);
            chan_r[1] <= CHAN_W'(in_if.source_pixel[15:8]);
            chan_r[2] <= CHAN_W'(in_if.source_pixel[7:0]);
            ch_r <= '0;
            ax_r <= AXIS_Y;
            if (in_if.action) begin
              state_r <= ST_R0;
            end else if (in_if.source_pixel[31:24] == 8'h00) begin
              state_r <= ST_IDLE;   // drop transparent pixel
            end else if (in_if.source_pixel[31:24] == ALPHA_OPAQUE) begin
              state_r <= ST_AX0;
            end else begin
              state_r <= ST_UNPM;
            end
          end
        end

        ST_DIV: begin
          div_rem_r <= rem_new;
          div_q_r   <= {div_q_r[SUM_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r - CNT_W'(1);
          if (div_cnt_r == '0) begin
            state_r <= ret_r;
          end
        end

        // Un-premultiply: channel * 255 / alpha
        ST_UNPM: begin
          div_q_r   <= SUM_W'(CHAN_W'(chan_r[ch_r][7:0]) * CHAN_W'(8'd255));
          div_d_r   <= AREA_W'(alpha);
          div_rem_r <= '0;
          div_cnt_r <= CNT_W'(SUM_W - 1);
          ret_r     <= ST_UNPM_ST;
          state_r   <= ST_DIV;
        end
        ST_UNPM_ST: begin
          chan_r[ch_r] <= div_q_r[CHAN_W-1:0];
          if (ch_r == LAST_CHAN) begin
            state_r <= ST_AX0;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= ST_UNPM;
          end
        end

        // Axis mapping: start, integer cell, then Q0.W fraction
        ST_AX0: begin
          prod_r  <= PROD_W'(ax_tgt) * PROD_W'(ax_loc);
          state_r <= ST_AX1;
        end
        ST_AX1: begin
          div_q_r   <= SUM_W'(prod_r);
          div_d_r   <= AREA_W'(ax_lvl);
          div_rem_r <= '0;
          div_cnt_r <= CNT_W'(SUM_W - 1);
          ret_r     <= ST_AX2;
          state_r   <= ST_DIV;
        end
        ST_AX2: begin
          start_r <= div_q_r[PROD_W-1:0];
          prod_r  <= PROD_W'(ax_pos) * PROD_W'(ax_tgt);
          state_r <= ST_AX3;
        end
        ST_AX3: begin
          div_q_r   <= SUM_W'(prod_r);
          div_d_r   <= AREA_W'(ax_lvl);
          div_rem_r <= '0;
          div_cnt_r <= CNT_W'(SUM_W - 1);
          ret_r     <= ST_AX4;
          state_r   <= ST_DIV;
        end
        ST_AX4: begin
          cell_r    <= $signed(CELL_W'(div_q_r[PROD_W-1:0])) - $signed(CELL_W'(start_r));
          div_q_r   <= SUM_W'({div_rem_r[COORD_W-1:0], {W{1'b0}}});
          div_d_r   <= AREA_W'(ax_lvl);
          div_rem_r <= '0;
          div_cnt_r <= CNT_W'(SUM_W - 1);
          ret_r     <= ST_AX5;
          state_r   <= ST_DIV;
        end
        ST_AX5: begin
          k_r <= '0;
          if (ax_r == AXIS_Y) begin
            cy_r <= cell_r;
            fy_r <= div_q_r[W-1:0];
            if (cell_r[CELL_W-1] || (cell_r >= $signed(CELL_W'(lvl_h_r)))) begin
              state_r <= ST_IDLE;   // row outside the level: drop whole pixel
            end else if (tgt_w_r == lvl_w_r) begin
              cx_r     <= $signed(CELL_W'(col_r)) - $signed(CELL_W'(loc_x_r));
              single_r <= 1'b1;
              state_r  <= ST_SP0;
            end else begin
              ax_r    <= AXIS_X;
              state_r <= ST_AX0;
            end
          end else begin
            cx_r     <= cell_r;
            fx_r     <= div_q_r[W-1:0];
            single_r <= 1'b0;
            state_r  <= ST_SP0;
          end
        end

        // Splat one corner: weight, bounds, read-modify-write
        ST_SP0: begin
          tx_r <= cx_r + (dx ? CELL_W'(1) : CELL_W'(0));
          ty_r <= cy_r + (dy ? CELL_W'(1) : CELL_W'(0));
          w_r  <= single_r ? WW'(1) << (2 * W) : WW'(wsel_x) * WW'(wsel_y);
          state_r <= ST_SP1;
        end
        ST_SP1: begin
          idx_r <= ADDR_W'(tx_r[FW_W-1:0]) + ADDR_W'(ty_r[FH_W-1:0]) * ADDR_W'(eff_fw);
          if (in_frame) begin
            state_r <= ST_SP2;
          end else if (last_corner) begin
            state_r <= ST_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ST_SP0;
          end
        end
        ST_SP2: begin
          state_r <= ST_SP3;
        end
        ST_SP3: begin
          acc_r   <= rd_data_r;
          ch_r    <= '0;
          state_r <= ST_SP4;
        end
        ST_SP4: begin
          case (ch_r)
            2'd0:    acc_r.red   <= acc_r.red   + SUM_W'(MUL_W'(chan_r[0]) * MUL_W'(w_r));
            2'd1:    acc_r.green <= acc_r.green + SUM_W'(MUL_W'(chan_r[1]) * MUL_W'(w_r));
            default: acc_r.blue  <= acc_r.blue  + SUM_W'(MUL_W'(chan_r[2]) * MUL_W'(w_r));
          endcase
          if (ch_r == LAST_CHAN) begin
            state_r <= ST_SP5;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_SP5: begin
          if (last_corner) begin
            state_r <= ST_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ST_SP0;
          end
        end

        // Readout: restart a stale index, divide sums by area (white if empty), clear entry
        ST_R0: begin
          tot_r   <= tot_now;
          idx_r   <= ({1'b0, rd_idx_r} >= tot_now) ? '0 : rd_idx_r;
          state_r <= ST_R1;
        end
        ST_R1: begin
          state_r <= ST_R2;
        end
        ST_R2: begin
          acc_r <= rd_data_r;
          ch_r  <= '0;
          if (rd_data_r.area == '0) begin
            q8_r[0] <= 8'hFF;
            q8_r[1] <= 8'hFF;
            q8_r[2] <= 8'hFF;
            state_r <= ST_R4;
          end else begin
            state_r <= ST_R3;
          end
        end
        ST_R3: begin
          div_q_r   <= acc_chan;
          div_d_r   <= acc_r.area;
          div_rem_r <= '0;
          div_cnt_r <= CNT_W'(SUM_W - 1);
          ret_r     <= ST_R3S;
          state_r   <= ST_DIV;
        end
        ST_R3S: begin
          q8_r[ch_r] <= div_q_r[7:0];
          if (ch_r == LAST_CHAN) begin
            state_r <= ST_R4;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= ST_R3;
          end
        end
        ST_R4: begin
          if (out_free) begin
            out_abgr_r  <= {8'hFF, q8_r[2], q8_r[1], q8_r[0]};
            out_argb_r  <= {8'hFF, q8_r[0], q8_r[1], q8_r[2]};
            out_last_r  <= (idx_inc == tot_r);
            rd_idx_r    <= (idx_inc >= tot_r) ? '0 : idx_inc[ADDR_W-1:0];
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A result appears only from the readout delivery step
  a_out_from_readout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_R4)
    else $error("result raised outside readout delivery");

  // The divider hands back only to the state that started it
  a_div_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV) || (state_r == $past(ret_r)))
    else $error("divider returned to the wrong state");

  // A splat address lies inside the current frame
  a_splat_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SP2) |-> ({1'b0, idx_r} < tot_now))
    else $error("splat address beyond frame");

  // No transaction is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_if.ready)
    else $error("transaction accepted during clearing pass");

endmodule
